// ===== design/wadm_pkg.sv =====
// shared constants for the weighted absolute deviation minimum search
package wadm_pkg;

  localparam int unsigned DEPTH_DEF       = 256;
  localparam int unsigned VALUE_BITS_DEF  = 20;
  localparam int unsigned WEIGHT_BITS_DEF = 20;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned COST_BITS = 49;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

endpackage

// ===== design/wadm_ram.sv =====
// generic single write port, single read port ram with registered read data
module wadm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/wadm_queue.sv =====
// short command queue between the load front end and the search back end
module wadm_queue
  import wadm_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/wadm_front.sv =====
// front end: accepts pairs, fills the store, tracks bounds, issues search commands
module wadm_front
  import wadm_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1),
  localparam int unsigned BW   = VALUE_BITS + 1,
  localparam int unsigned CMDW = CNTW + 2 * BW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [VALUE_BITS-1:0]         sample_value_i,
  input  logic [WEIGHT_BITS-1:0]        sample_weight_i,
  input  logic                          last_pair_i,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic [VALUE_BITS+WEIGHT_BITS-1:0] wr_data_o,
  output logic                          cmd_push_o,
  output logic [CMDW-1:0]               cmd_o,
  input  logic                          cmd_full_i,
  input  logic                          search_done_i
);

  logic [CNTW-1:0] count_q, count_d, count_n;
  logic [BW-1:0]   lo_q, lo_d, lo_n;
  logic [BW-1:0]   hi_q, hi_d, hi_n;
  logic            wait_q, wait_d;
  logic            accept, store;
  logic [BW-1:0]   v_ext;

  assign busy    = wait_q || cmd_full_i;
  assign accept  = start && !busy;
  assign store   = accept && (count_q < CNTW'(DEPTH));
  assign v_ext   = {1'b0, sample_value_i};

  assign wr_en_o   = store;
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = {sample_value_i, sample_weight_i};

  always_comb begin
    count_n = count_q;
    lo_n    = lo_q;
    hi_n    = hi_q;
    if (store) begin
      count_n = count_q + CNTW'(1);
      if (v_ext < lo_q) begin
        lo_n = v_ext;
      end
      if (v_ext > hi_q) begin
        hi_n = v_ext;
      end
    end
  end

  assign cmd_push_o = accept && last_pair_i;
  assign cmd_o      = {count_n, lo_n, hi_n};

  always_comb begin
    count_d = count_n;
    lo_d    = lo_n;
    hi_d    = hi_n;
    wait_d  = wait_q;
    if (search_done_i) begin
      wait_d = 1'b0;
    end
    if (cmd_push_o) begin
      count_d = '0;
      lo_d    = '1;
      hi_d    = '0;
      wait_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '1;
      hi_q    <= '0;
      wait_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      wait_q  <= wait_d;
    end
  end

endmodule

// ===== design/wadm_back.sv =====
// back end: bisection search, one pass over the store per probe
module wadm_back
  import wadm_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1),
  localparam int unsigned BW   = VALUE_BITS + 1,
  localparam int unsigned CMDW = CNTW + 2 * BW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  logic [CMDW-1:0]                   cmd_i,
  output logic                              cmd_pop_o,
  output logic                              rd_en_o,
  output logic [AW-1:0]                     rd_addr_o,
  input  logic [VALUE_BITS+WEIGHT_BITS-1:0] rd_data_i,
  output logic                              search_done_o,
  output logic                              result_valid_o,
  output logic [COST_BITS-1:0]              minimum_cost_o
);

  localparam int unsigned SW = VALUE_BITS + 2;
  localparam int unsigned DW = VALUE_BITS + 1;
  localparam int unsigned PW = DW + WEIGHT_BITS;
  localparam int unsigned XW = (PW > COST_BITS) ? PW : COST_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PROBE  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_DECIDE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [CNTW-1:0]        idx_q, idx_d;
  logic signed [SW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [COST_BITS-1:0]   best_q, best_d;
  logic                   rd_vld_q, prod_vld_q;
  logic [PW-1:0]          prod_q [3];
  logic [PW-1:0]          prod_d [3];
  logic [COST_BITS-1:0]   sum_q [3];
  logic [COST_BITS-1:0]   sum_d [3];

  logic [VALUE_BITS-1:0]  rd_v;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic signed [SW-1:0]   pt [3];
  logic signed [SW-1:0]   diff [3];
  logic [SW-1:0]          mag [3];
  logic [XW-1:0]          pext [3];
  logic [COST_BITS-1:0]   psat [3];
  logic [COST_BITS:0]     acc [3];

  logic [CNTW-1:0]        cmd_cnt;
  logic [BW-1:0]          cmd_lo, cmd_hi;
  logic signed [SW-1:0]   span, next_lo, next_hi;
  logic [COST_BITS-1:0]   left_c, here_c, right_c;
  logic                   stop;

  assign {cmd_cnt, cmd_lo, cmd_hi} = cmd_i;
  assign {rd_v, rd_w} = rd_data_i;

  assign rd_en_o   = (state_q == S_SCAN);
  assign rd_addr_o = idx_q[AW-1:0];
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  // distances and products for mid-1, mid, mid+1
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt[k]     = mid_q - SW'(1) + SW'(k);
      diff[k]   = $signed({2'b00, rd_v}) - pt[k];
      mag[k]    = diff[k][SW-1] ? SW'(-diff[k]) : SW'(diff[k]);
      prod_d[k] = PW'(mag[k][DW-1:0]) * PW'(rd_w);
    end
  end

  // saturating accumulation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pext[k] = XW'(prod_q[k]);
      psat[k] = (pext[k] > XW'(COST_MAX)) ? COST_MAX : pext[k][COST_BITS-1:0];
      acc[k]  = {1'b0, sum_q[k]} + {1'b0, psat[k]};
    end
  end

  assign left_c  = sum_q[0];
  assign here_c  = sum_q[1];
  assign right_c = sum_q[2];
  assign span    = hi_q - lo_q;

  always_comb begin
    stop    = 1'b0;
    next_lo = lo_q;
    next_hi = hi_q;
    if ((here_c < left_c) && (here_c < right_c)) begin
      stop = 1'b1;
    end else if ((here_c < left_c) && (here_c > right_c)) begin
      next_lo = mid_q + SW'(1);
    end else begin
      next_hi = mid_q - SW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    best_d  = best_q;
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = sum_q[k];
      if (prod_vld_q) begin
        sum_d[k] = (acc[k] > {1'b0, COST_MAX}) ? COST_MAX : acc[k][COST_BITS-1:0];
      end
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cnt_d   = cmd_cnt;
          lo_d    = $signed({1'b0, cmd_lo});
          hi_d    = $signed({1'b0, cmd_hi});
          best_d  = COST_MAX;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        mid_d = lo_q + (span >>> 1);
        idx_d = '0;
        for (int k = 0; k < 3; k++) begin
          sum_d[k] = '0;
        end
        state_d = S_SCAN;
      end
      S_SCAN: begin
        idx_d = idx_q + CNTW'(1);
        if (idx_q == cnt_q - CNTW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (here_c < best_q) begin
          best_d = here_c;
        end
        lo_d = next_lo;
        hi_d = next_hi;
        if (stop || (next_lo > next_hi)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_EMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      best_q     <= COST_MAX;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_en_o;
      prod_vld_q <= rd_vld_q;
      best_q     <= best_d;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  assign search_done_o  = (state_q == S_EMIT);
  assign result_valid_o = (state_q == S_EMIT);
  assign minimum_cost_o = best_q;

  a_prod_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> $past(rd_vld_q))
    else $error("product stage valid without a read");

  a_decide_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> (!rd_vld_q && !prod_vld_q))
    else $error("decision taken before the pass drained");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (idx_q < cnt_q))
    else $error("read beyond loaded pairs");

  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) && ($past(state_q) != S_IDLE)) |-> (best_q <= $past(best_q)))
    else $error("best cost rose during a search");

endmodule

// ===== design/weighted_abs_deviation_min_search.sv =====
// top level of the weighted absolute deviation minimum search
//
// Input channel: an item (sample_value_i, sample_weight_i, last_pair_i) is
// taken at a rising edge with start high and busy low. Items load one per
// cycle into the store while busy is low; pairs past DEPTH are dropped,
// but their last flag still counts. After an item with last_pair_i set,
// busy stays high until the search result has been delivered.
// Output channel: minimum_cost_o is valid for exactly one cycle while
// result_valid_o is high; the receiver cannot stall, so there is no backpressure.
// Search: each probe runs a setup step, one store read per pair, a drain of the
// read, product and accumulate stages, then a decision step, and a search takes
// at most VALUE_BITS + 1 probes. The next set may start in the cycle after the
// result strobe.
// Reset: asynchronous, active low; clears the pair count, bounds, best cost
// and all control state. No clearing pass is needed; unwritten store entries
// are never read.
module weighted_abs_deviation_min_search
  import wadm_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_BITS-1:0]  sample_value_i,
  input  logic [WEIGHT_BITS-1:0] sample_weight_i,
  input  logic                   last_pair_i,
  output logic                   result_valid_o,
  output logic [COST_BITS-1:0]   minimum_cost_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned BW   = VALUE_BITS + 1;
  localparam int unsigned CMDW = CNTW + 2 * BW;
  localparam int unsigned RW   = VALUE_BITS + WEIGHT_BITS;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [RW-1:0]   wr_data, rd_data;
  logic            cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic [CMDW-1:0] cmd_in, cmd_out;
  logic            search_done;

  wadm_front #(
    .DEPTH       (DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_value_i  (sample_value_i),
    .sample_weight_i (sample_weight_i),
    .last_pair_i     (last_pair_i),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in),
    .cmd_full_i      (cmd_full),
    .search_done_i   (search_done)
  );

  wadm_queue #(
    .WIDTH (CMDW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .valid_o (cmd_valid)
  );

  wadm_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  wadm_back #(
    .DEPTH       (DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd_out),
    .cmd_pop_o      (cmd_pop),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .search_done_o  (search_done),
    .result_valid_o (result_valid_o),
    .minimum_cost_o (minimum_cost_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the weighted absolute deviation minimum search
module tb;
  import wadm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned VALUE_BITS   = VALUE_BITS_DEF;
  localparam int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF;
  localparam int unsigned ITEM_TARGET  = 1600;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam longint unsigned COST_LIMIT = (64'd1 << COST_BITS) - 1;
  localparam logic [VALUE_BITS-1:0]  VALUE_TOP  = '1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_TOP = '1;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_CLUSTER,
    SPREAD_EDGES,
    SPREAD_BAND
  } value_spread_e;

  typedef enum int unsigned {
    WEIGHT_FULL,
    WEIGHT_LOW,
    WEIGHT_BINARY,
    WEIGHT_MAX
  } weight_mix_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [VALUE_BITS-1:0]  sample_value_i = '0;
  logic [WEIGHT_BITS-1:0] sample_weight_i = '0;
  logic                   last_pair_i = 1'b0;
  logic                   result_valid_o;
  logic [COST_BITS-1:0]   minimum_cost_o;

  weighted_abs_deviation_min_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_value_i  (sample_value_i),
    .sample_weight_i (sample_weight_i),
    .last_pair_i     (last_pair_i),
    .result_valid_o  (result_valid_o),
    .minimum_cost_o  (minimum_cost_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state: the set of pairs loaded so far
  logic [VALUE_BITS-1:0]  held_value  [DEPTH];
  logic [WEIGHT_BITS-1:0] held_weight [DEPTH];
  int unsigned            held_count = 0;
  longint                 held_lo = (longint'(1) << (VALUE_BITS + 1)) - 1;
  longint                 held_hi = 0;

  longint unsigned expected_costs [$];
  longint unsigned cost_want;
  int unsigned     items_sent = 0;
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;
  bit              back_to_back = 1'b0;

  function automatic longint unsigned cost_at_point(input longint x);
    longint unsigned sum;
    longint unsigned gap;
    longint unsigned prod;
    longint          v;
    sum = 0;
    for (int unsigned i = 0; i < held_count; i++) begin
      v = longint'(held_value[i]);
      gap = (v >= x) ? longint'(v - x) : longint'(x - v);
      prod = gap * longint'(held_weight[i]);
      if (prod > COST_LIMIT) prod = COST_LIMIT;
      sum = sum + prod;
      if (sum > COST_LIMIT) sum = COST_LIMIT;
    end
    return sum;
  endfunction

  function automatic longint unsigned search_min_cost();
    longint          lo;
    longint          hi;
    longint          mid;
    longint unsigned left;
    longint unsigned here;
    longint unsigned right;
    longint unsigned best;
    lo = held_lo;
    hi = held_hi;
    best = COST_LIMIT;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      left = cost_at_point(mid - 1);
      here = cost_at_point(mid);
      right = cost_at_point(mid + 1);
      if (here < best) best = here;
      if (here < left && here < right) break;
      else if (here < left && here > right) lo = mid + 1;
      else hi = mid - 1;
    end
    return best;
  endfunction

  function automatic void record_pair(input logic [VALUE_BITS-1:0] v,
                                      input logic [WEIGHT_BITS-1:0] w, input logic last);
    if (held_count < DEPTH) begin
      held_value[held_count] = v;
      held_weight[held_count] = w;
      held_count++;
      if (longint'(v) < held_lo) held_lo = longint'(v);
      if (longint'(v) > held_hi) held_hi = longint'(v);
    end
    if (last) begin
      expected_costs.push_back(search_min_cost());
      held_count = 0;
      held_lo = (longint'(1) << (VALUE_BITS + 1)) - 1;
      held_hi = 0;
    end
  endfunction

  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_pair(input logic [VALUE_BITS-1:0] v, input logic [WEIGHT_BITS-1:0] w,
                           input logic last);
    start <= 1'b1;
    sample_value_i <= v;
    sample_weight_i <= w;
    last_pair_i <= last;
    do @(posedge clk_i); while (busy);
    items_sent++;
    record_pair(v, w, last);
    if (!back_to_back) sender_gap();
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input value_spread_e spread,
                                                       input logic [VALUE_BITS-1:0] base);
    case (spread)
      SPREAD_CLUSTER: return base + VALUE_BITS'($urandom_range(0, 15));
      SPREAD_EDGES: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return VALUE_BITS'(1);
          2: return VALUE_TOP - VALUE_BITS'(1);
          default: return VALUE_TOP;
        endcase
      end
      SPREAD_BAND: return base + VALUE_BITS'($urandom_range(0, 1023));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight(input weight_mix_e mix);
    case (mix)
      WEIGHT_LOW: return WEIGHT_BITS'($urandom_range(0, 7));
      WEIGHT_BINARY: return $urandom_range(0, 1) ? WEIGHT_TOP : '0;
      WEIGHT_MAX: return WEIGHT_TOP;
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int unsigned pairs, input value_spread_e spread,
                                 input weight_mix_e mix);
    logic [VALUE_BITS-1:0] base;
    base = VALUE_BITS'($urandom);
    for (int unsigned i = 0; i < pairs; i++) begin
      send_pair(pick_value(spread, base), pick_weight(mix), i == pairs - 1);
    end
  endtask

  task automatic test_single_pairs();
    send_pair('0, '0, 1'b1);
    send_pair(VALUE_TOP, WEIGHT_TOP, 1'b1);
    send_pair('0, WEIGHT_TOP, 1'b1);
    send_pair(VALUE_TOP, WEIGHT_BITS'(1), 1'b1);
  endtask

  task automatic test_extreme_sets();
    send_pair('0, WEIGHT_TOP, 1'b0);
    send_pair(VALUE_TOP, WEIGHT_TOP, 1'b1);
    send_pair(VALUE_TOP, WEIGHT_TOP, 1'b0);
    send_pair(VALUE_TOP, '0, 1'b0);
    send_pair('0, WEIGHT_BITS'(1), 1'b1);
  endtask

  // zero weights and an even split give flat costs
  task automatic test_ties();
    send_pair(VALUE_BITS'(5), '0, 1'b0);
    send_pair(VALUE_BITS'(9), '0, 1'b0);
    send_pair(VALUE_BITS'(7), '0, 1'b1);
    send_pair(VALUE_BITS'(10), WEIGHT_BITS'(3), 1'b0);
    send_pair(VALUE_BITS'(12), WEIGHT_BITS'(3), 1'b1);
  endtask

  // pairs past the store size are dropped but the last flag still counts
  task automatic test_store_full();
    send_random_set(DEPTH + $urandom_range(1, 4), SPREAD_FULL, WEIGHT_FULL);
    send_random_set(DEPTH + 1, SPREAD_EDGES, WEIGHT_MAX);
  endtask

  task automatic test_random_sets();
    int unsigned r;
    int unsigned pairs;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) pairs = $urandom_range(1, 8);
      else if (r < 96) pairs = $urandom_range(9, 40);
      else pairs = $urandom_range(41, 150);
      back_to_back = ($urandom_range(0, 3) == 0);
      send_random_set(pairs, value_spread_e'($urandom_range(0, 3)),
                      weight_mix_e'($urandom_range(0, 3)));
    end
    back_to_back = 1'b0;
  endtask

  task automatic note_mismatch(input longint unsigned want, input logic [COST_BITS-1:0] got,
                               input bit unexpected);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected) $display("mismatch: result %0d with no item pending", got);
      else $display("mismatch: minimum_cost expected %0d got %0d", want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_costs.size() == 0) begin
        note_mismatch(0, minimum_cost_o, 1'b1);
      end else begin
        cost_want = expected_costs.pop_front();
        if (minimum_cost_o !== cost_want[COST_BITS-1:0]) begin
          note_mismatch(cost_want, minimum_cost_o, 1'b0);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_pairs();
    test_extreme_sets();
    test_ties();
    test_store_full();
    test_random_sets();
    start <= 1'b0;
    while (expected_costs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
